// ===== src/wsu_pkg.sv =====
`timescale 1ns / 1ps

package wsu_pkg;

    localparam logic [7:0] CH_CR = 8'd13;
    localparam logic [7:0] CH_LF = 8'd10;

    localparam int METH_LEN     = 5;
    localparam int CONN_LEN     = 12;
    localparam int UPG_LEN      = 9;
    localparam int KEY_LEN      = 19;
    localparam int CONN_VAL_LEN = 7;
    localparam int UPG_VAL_LEN  = 9;

    localparam logic [8*METH_LEN-1:0]     METH_TXT     = "GET /";
    localparam logic [8*CONN_LEN-1:0]     CONN_TXT     = "connection: ";
    localparam logic [8*UPG_LEN-1:0]      UPG_TXT      = "upgrade: ";
    localparam logic [8*KEY_LEN-1:0]      KEY_TXT      = "sec-websocket-key: ";
    localparam logic [8*CONN_VAL_LEN-1:0] CONN_VAL_TXT = "upgrade";
    localparam logic [8*UPG_VAL_LEN-1:0]  UPG_VAL_TXT  = "websocket";

    localparam logic [4:0] LINE_POS_MAX = 5'd31;

    localparam logic [2:0] VERDICT_OK       = 3'd0;
    localparam logic [2:0] VERDICT_BAD_METH = 3'd1;
    localparam logic [2:0] VERDICT_BAD_CONN = 3'd2;
    localparam logic [2:0] VERDICT_BAD_UPG  = 3'd3;
    localparam logic [2:0] VERDICT_NO_KEY   = 3'd4;

    localparam logic OUT_KEY     = 1'b0;
    localparam logic OUT_VERDICT = 1'b1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        logic       out_kind;
        logic [7:0] key_char;
        logic       key_restart;
        logic [2:0] verdict;
    } out_beat_t;

    // classified byte handed from front to back
    typedef struct packed {
        logic [7:0] raw;
        logic [7:0] folded;
        logic       is_cr;
        logic       is_lf;
        logic       last;
    } item_t;

    function automatic logic [7:0] fold_char(logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic logic [7:0] meth_ch(logic [2:0] i);
        return (int'(i) < METH_LEN) ? METH_TXT[8*(METH_LEN-1-int'(i)) +: 8] : 8'h00;
    endfunction

    function automatic logic [7:0] conn_ch(logic [3:0] i);
        return (int'(i) < CONN_LEN) ? CONN_TXT[8*(CONN_LEN-1-int'(i)) +: 8] : 8'h00;
    endfunction

    function automatic logic [7:0] upg_ch(logic [3:0] i);
        return (int'(i) < UPG_LEN) ? UPG_TXT[8*(UPG_LEN-1-int'(i)) +: 8] : 8'h00;
    endfunction

    function automatic logic [7:0] key_ch(logic [4:0] i);
        return (int'(i) < KEY_LEN) ? KEY_TXT[8*(KEY_LEN-1-int'(i)) +: 8] : 8'h00;
    endfunction

    function automatic logic [7:0] conn_val_ch(logic [2:0] i);
        return (int'(i) < CONN_VAL_LEN) ?
            CONN_VAL_TXT[8*(CONN_VAL_LEN-1-int'(i)) +: 8] : 8'h00;
    endfunction

    function automatic logic [7:0] upg_val_ch(logic [3:0] i);
        return (int'(i) < UPG_VAL_LEN) ?
            UPG_VAL_TXT[8*(UPG_VAL_LEN-1-int'(i)) +: 8] : 8'h00;
    endfunction

endpackage

// ===== src/wsu_front.sv =====
`timescale 1ns / 1ps

module wsu_front
    import wsu_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_beat_t s_data,
    output logic     f_valid,
    input  logic     f_ready,
    output item_t    f_item
);

    logic  valid_reg, valid_next;
    item_t item_reg;
    item_t item_class;

    always_comb begin
        item_class.raw    = s_data.data_byte;
        item_class.folded = fold_char(s_data.data_byte);
        item_class.is_cr  = (s_data.data_byte == CH_CR);
        item_class.is_lf  = (s_data.data_byte == CH_LF);
        item_class.last   = s_data.last_byte;
    end

    assign s_ready = !valid_reg || f_ready;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (f_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= item_class;
        end
    end

    assign f_valid = valid_reg;
    assign f_item  = item_reg;

endmodule

// ===== src/wsu_queue.sv =====
`timescale 1ns / 1ps

module wsu_queue
    import wsu_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output item_t out_item
);

    item_t                  slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   push, pop;

    assign in_ready  = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== src/wsu_back.sv =====
`timescale 1ns / 1ps

module wsu_back
    import wsu_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      q_valid,
    output logic      q_ready,
    input  item_t     q_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    // per-line match state; seen[3] marks key bytes already sent on this line
    typedef struct packed {
        logic [4:0] line_pos;
        logic [2:0] prefix;
        logic [1:0] value;
        logic [3:0] seen;
    } line_st_t;

    typedef struct packed {
        line_st_t   st;
        logic       emit;
        logic       restart;
    } take_res_t;

    localparam line_st_t LINE_RESET = '{line_pos: 5'd0, prefix: 3'b111, value: 2'b11,
                                        seen: 4'd0};

    function automatic take_res_t take_char(line_st_t st, logic [7:0] f, logic may_emit);
        take_res_t  r;
        logic [4:0] p;
        logic [4:0] v;
        r.st      = st;
        r.emit    = 1'b0;
        r.restart = 1'b0;
        p         = st.line_pos;
        if (p < 5'(CONN_LEN) && f != conn_ch(p[3:0])) r.st.prefix[0] = 1'b0;
        if (p < 5'(UPG_LEN) && f != upg_ch(p[3:0]))   r.st.prefix[1] = 1'b0;
        if (p < 5'(KEY_LEN) && f != key_ch(p))        r.st.prefix[2] = 1'b0;
        if (p >= 5'(CONN_LEN)) begin
            v = p - 5'(CONN_LEN);
            if (v >= 5'(CONN_VAL_LEN) || f != conn_val_ch(v[2:0])) r.st.value[0] = 1'b0;
        end
        if (p >= 5'(UPG_LEN)) begin
            v = p - 5'(UPG_LEN);
            if (v >= 5'(UPG_VAL_LEN) || f != upg_val_ch(v[3:0])) r.st.value[1] = 1'b0;
        end
        if (p != LINE_POS_MAX) r.st.line_pos = p + 5'd1;
        if (may_emit && p >= 5'(KEY_LEN) && r.st.prefix[2]) begin
            r.emit    = 1'b1;
            r.restart = !st.seen[3];
            r.st.seen[3] = 1'b1;
            if (!st.seen[3]) r.st.seen[2] = 1'b0;
        end
        return r;
    endfunction

    function automatic line_st_t line_commit(line_st_t st);
        line_st_t n;
        n = LINE_RESET;
        n.seen = st.seen;
        if (st.prefix[0] && st.value[0] && st.line_pos == 5'(CONN_LEN + CONN_VAL_LEN))
            n.seen[0] = 1'b1;
        if (st.prefix[1] && st.value[1] && st.line_pos == 5'(UPG_LEN + UPG_VAL_LEN))
            n.seen[1] = 1'b1;
        if (st.prefix[2] && st.seen[3])
            n.seen[2] = 1'b1;
        n.seen[3] = 1'b0;
        return n;
    endfunction

    function automatic logic [2:0] verdict_code(logic mok, logic [2:0] bi, logic [3:0] seen);
        if (!(mok && bi >= 3'(METH_LEN))) return VERDICT_BAD_METH;
        if (!seen[0]) return VERDICT_BAD_CONN;
        if (!seen[1]) return VERDICT_BAD_UPG;
        if (!seen[2]) return VERDICT_NO_KEY;
        return VERDICT_OK;
    endfunction

    line_st_t  st_reg, st_next;
    logic      method_ok_reg, method_ok_next;
    logic      cr_pending_reg, cr_pending_next;
    logic      verdict_given_reg, verdict_given_next;
    logic [2:0] byte_index_reg, byte_index_next;
    logic      m_valid_reg, m_valid_next;
    out_beat_t m_data_reg;
    logic      fire;
    logic      res_valid;
    out_beat_t res;
    take_res_t tc_cr, tc_byte;

    assign fire    = q_valid && (!m_valid_reg || m_ready);
    assign q_ready = fire;

    // bare CR replayed into the line first, then the current byte on top
    assign tc_cr   = take_char(st_reg, CH_CR, 1'b0);
    assign tc_byte = take_char(cr_pending_reg ? tc_cr.st : st_reg, q_item.folded, !q_item.last);

    always_comb begin
        st_next            = st_reg;
        method_ok_next     = method_ok_reg;
        cr_pending_next    = cr_pending_reg;
        verdict_given_next = verdict_given_reg;
        byte_index_next    = byte_index_reg;
        res_valid          = 1'b0;
        res                = '0;
        if (fire) begin
            if (!verdict_given_reg) begin
                if (byte_index_reg < 3'(METH_LEN)) begin
                    if (q_item.raw != meth_ch(byte_index_reg)) method_ok_next = 1'b0;
                    byte_index_next = byte_index_reg + 3'd1;
                end
                if (cr_pending_reg) begin
                    if (q_item.is_lf) begin
                        cr_pending_next = 1'b0;
                        if (st_reg.line_pos == 5'd0) begin
                            res_valid          = 1'b1;
                            res.out_kind       = OUT_VERDICT;
                            res.verdict        = verdict_code(method_ok_next, byte_index_next,
                                                              st_reg.seen);
                            verdict_given_next = 1'b1;
                        end else begin
                            st_next = line_commit(st_reg);
                        end
                    end else if (q_item.is_cr) begin
                        st_next = tc_cr.st;
                    end else begin
                        cr_pending_next = 1'b0;
                        st_next         = tc_byte.st;
                    end
                end else if (q_item.is_cr) begin
                    cr_pending_next = 1'b1;
                end else begin
                    st_next = tc_byte.st;
                end
                // an LF without a CR before it is an ordinary line byte
                if (tc_byte.emit && !q_item.is_cr && !(cr_pending_reg && q_item.is_lf)) begin
                    res_valid       = 1'b1;
                    res.out_kind    = OUT_KEY;
                    res.key_char    = q_item.raw;
                    res.key_restart = tc_byte.restart;
                end
            end
            if (q_item.last) begin
                if (!verdict_given_next) begin
                    res_valid   = 1'b1;
                    res         = '0;
                    res.out_kind = OUT_VERDICT;
                    res.verdict = verdict_code(method_ok_next, byte_index_next, st_next.seen);
                end
                st_next            = LINE_RESET;
                method_ok_next     = 1'b1;
                cr_pending_next    = 1'b0;
                verdict_given_next = 1'b0;
                byte_index_next    = 3'd0;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (fire) begin
            m_valid_next = res_valid;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg            <= LINE_RESET;
            method_ok_reg     <= 1'b1;
            cr_pending_reg    <= 1'b0;
            verdict_given_reg <= 1'b0;
            byte_index_reg    <= 3'd0;
            m_valid_reg       <= 1'b0;
        end else begin
            st_reg            <= st_next;
            method_ok_reg     <= method_ok_next;
            cr_pending_reg    <= cr_pending_next;
            verdict_given_reg <= verdict_given_next;
            byte_index_reg    <= byte_index_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && res_valid) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== src/ws_upgrade_request_checker.sv =====
// WebSocket upgrade request checker.
// Input channel (s_valid/s_ready/s_data) carries the request text, one byte per
// beat; s_data.last_byte marks the final byte of a request. Lines are split at
// CR LF and the request line and the Connection, Upgrade and Sec-WebSocket-Key
// headers are checked. Result channel (m_valid/m_ready/m_data) carries either a
// key byte (out_kind 0, key_restart on the first byte of a new key value) or
// one verdict per request (out_kind 1) at the blank line or the last byte.
// Throughput: one byte per cycle while the output is not stalled by m_ready,
// set by the per-byte update of the line state in the back end. A result
// passes through the classify register and the queue, then into the output
// register.
// Reset (aresetn low, synchronous) empties the pipeline and returns the
// checker to the start of a request. When m_ready is low the finished beat
// holds in the output register; the queue and classify stage keep taking
// bytes until they fill, then s_ready drops.
`timescale 1ns / 1ps

module ws_upgrade_request_checker
    import wsu_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    logic  f_valid, f_ready;
    item_t f_item;
    logic  q_valid, q_ready;
    item_t q_item;

    wsu_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .f_valid (f_valid),
        .f_ready (f_ready),
        .f_item  (f_item)
    );

    wsu_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    wsu_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // a result only appears after the queue offered a byte
    a_out_from_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(q_valid))
        else $error("result beat without a queued byte");

    a_verdict_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.out_kind == OUT_VERDICT) |->
        (m_data.key_char == 8'd0 && !m_data.key_restart && m_data.verdict <= VERDICT_NO_KEY))
        else $error("malformed verdict beat");

    a_key_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.out_kind == OUT_KEY) |->
        (m_data.verdict == VERDICT_OK && m_data.key_char != CH_CR))
        else $error("malformed key beat");

    // back end pops only while the output register can take the result
    a_pop_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && q_ready) |-> (!m_valid || m_ready))
        else $error("queue popped while output stalled");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import wsu_pkg::*;

    typedef enum int {
        HDR_CONN,
        HDR_UPG,
        HDR_KEY,
        HDR_NEAR,
        HDR_JUNK
    } header_kind_t;

    localparam logic [8*METH_LEN-1:0]     REQ_START   = "GET /";
    localparam logic [8*CONN_LEN-1:0]     CONN_NAME   = "connection: ";
    localparam logic [8*UPG_LEN-1:0]      UPG_NAME    = "upgrade: ";
    localparam logic [8*KEY_LEN-1:0]      KEY_NAME    = "sec-websocket-key: ";
    localparam logic [8*CONN_VAL_LEN-1:0] CONN_WORD   = "upgrade";
    localparam logic [8*UPG_VAL_LEN-1:0]  UPG_WORD    = "websocket";
    localparam int                        SHOWN_LIMIT = 10;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_data;

    ws_upgrade_request_checker dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // tracked request state
    logic [4:0] line_pos;
    logic [2:0] name_live;    // connection / upgrade / key header names still matching
    logic [1:0] value_live;   // "upgrade" / "websocket" values still matching
    logic [3:0] seen;         // conn ok, upgrade ok, key set, key bytes in this line
    logic       method_good;
    logic       cr_held;
    logic       verdict_done;
    logic [2:0] method_cnt;

    out_beat_t awaited_beats[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_len      = 0;
    int hold_reqs     = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    int bytes_sent    = 0;
    int requests      = 0;
    int key_beats     = 0;
    int verdict_beats = 0;
    int verdict_count[5] = '{0, 0, 0, 0, 0};
    int mismatches    = 0;
    int leftover      = 0;

    function automatic logic [7:0] text_at(input logic [8*KEY_LEN-1:0] txt, input int len,
                                           input int idx);
        return txt[8*(len-1-idx) +: 8];
    endfunction

    function automatic logic [7:0] lower(input logic [7:0] c);
        if (c >= "A" && c <= "Z") begin
            return c + 8'd32;
        end
        return c;
    endfunction

    task automatic new_line();
        line_pos   = '0;
        name_live  = 3'b111;
        value_live = 2'b11;
        seen[3]    = 1'b0;
    endtask

    task automatic clear_request();
        seen = '0;
        new_line();
        method_good  = 1'b1;
        cr_held      = 1'b0;
        verdict_done = 1'b0;
        method_cnt   = '0;
    endtask

    function automatic out_beat_t verdict_beat();
        out_beat_t r;
        r = '0;
        r.out_kind = OUT_VERDICT;
        if (!(method_good && method_cnt >= METH_LEN)) r.verdict = VERDICT_BAD_METH;
        else if (!seen[0]) r.verdict = VERDICT_BAD_CONN;
        else if (!seen[1]) r.verdict = VERDICT_BAD_UPG;
        else if (!seen[2]) r.verdict = VERDICT_NO_KEY;
        else r.verdict = VERDICT_OK;
        return r;
    endfunction

    task automatic scan_char(input logic [7:0] c, input bit may_emit, inout out_beat_t res,
                             inout bit have);
        int p;
        logic [7:0] f;
        p = line_pos;
        f = lower(c);
        if (p < CONN_LEN && f != text_at(CONN_NAME, CONN_LEN, p)) name_live[0] = 1'b0;
        if (p < UPG_LEN && f != text_at(UPG_NAME, UPG_LEN, p)) name_live[1] = 1'b0;
        if (p < KEY_LEN && f != text_at(KEY_NAME, KEY_LEN, p)) name_live[2] = 1'b0;
        if (p >= CONN_LEN) begin
            if (p - CONN_LEN >= CONN_VAL_LEN ||
                f != text_at(CONN_WORD, CONN_VAL_LEN, p - CONN_LEN)) value_live[0] = 1'b0;
        end
        if (p >= UPG_LEN) begin
            if (p - UPG_LEN >= UPG_VAL_LEN ||
                f != text_at(UPG_WORD, UPG_VAL_LEN, p - UPG_LEN)) value_live[1] = 1'b0;
        end
        if (line_pos != LINE_POS_MAX) line_pos = line_pos + 5'd1;
        if (may_emit && p >= KEY_LEN && name_live[2]) begin
            res = '0;
            res.out_kind    = OUT_KEY;
            res.key_char    = c;
            res.key_restart = !seen[3];
            // a new key value drops the one before it until its line ends
            if (!seen[3]) seen[2] = 1'b0;
            seen[3] = 1'b1;
            have = 1'b1;
        end
    endtask

    task automatic end_line();
        if (name_live[0] && value_live[0] && line_pos == CONN_LEN + CONN_VAL_LEN)
            seen[0] = 1'b1;
        if (name_live[1] && value_live[1] && line_pos == UPG_LEN + UPG_VAL_LEN)
            seen[1] = 1'b1;
        if (name_live[2] && seen[3]) seen[2] = 1'b1;
        new_line();
    endtask

    task automatic track_request_byte(input in_beat_t beat);
        out_beat_t res;
        bit have;
        logic [7:0] b;
        res  = '0;
        have = 1'b0;
        b    = beat.data_byte;
        if (!verdict_done) begin
            if (method_cnt < METH_LEN) begin
                if (b != text_at(REQ_START, METH_LEN, method_cnt)) method_good = 1'b0;
                method_cnt = method_cnt + 3'd1;
            end
            if (cr_held) begin
                if (b == CH_LF) begin
                    cr_held = 1'b0;
                    if (line_pos == 0) begin
                        res = verdict_beat();
                        have = 1'b1;
                        verdict_done = 1'b1;
                    end else begin
                        end_line();
                    end
                end else begin
                    // the held CR was bare: it counts as line content, never as a key byte
                    scan_char(CH_CR, 1'b0, res, have);
                    if (b != CH_CR) begin
                        cr_held = 1'b0;
                        scan_char(b, !beat.last_byte, res, have);
                    end
                end
            end else if (b == CH_CR) begin
                cr_held = 1'b1;
            end else begin
                scan_char(b, !beat.last_byte, res, have);
            end
        end
        if (beat.last_byte) begin
            if (!verdict_done) begin
                res = verdict_beat();
                have = 1'b1;
            end
            clear_request();
        end
        if (have) awaited_beats.push_back(res);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_request();
        end else if (s_valid && s_ready) begin
            track_request_byte(s_data);
        end
    end

    task automatic log_mismatch(input string what, input out_beat_t want, input out_beat_t got);
        mismatches++;
        if (mismatches <= SHOWN_LIMIT) begin
            $display("mismatch %0d at %0t: %s", mismatches, $time, what);
            $display("  expected kind=%0d char=%02h restart=%0d verdict=%0d",
                     want.out_kind, want.key_char, want.key_restart, want.verdict);
            $display("  got      kind=%0d char=%02h restart=%0d verdict=%0d",
                     got.out_kind, got.key_char, got.key_restart, got.verdict);
        end
    endtask

    always @(posedge aclk) begin
        out_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (m_data.out_kind == OUT_KEY) begin
                key_beats++;
            end else begin
                verdict_beats++;
                if (m_data.verdict <= VERDICT_NO_KEY) verdict_count[m_data.verdict]++;
            end
            if (awaited_beats.size() == 0) begin
                log_mismatch("result beat with nothing expected", '0, m_data);
            end else begin
                want = awaited_beats.pop_front();
                if (m_data.out_kind !== want.out_kind || m_data.key_char !== want.key_char ||
                    m_data.key_restart !== want.key_restart ||
                    m_data.verdict !== want.verdict) begin
                    log_mismatch("wrong field", want, m_data);
                end
            end
        end
    end

    // result side: random stalls, plus a long hold-off on request
    always @(negedge aclk) begin
        if (hold_reqs != hold_served) begin
            hold_served = hold_reqs;
            hold_left   = hold_len;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_byte(input logic [7:0] d, input bit last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= {d, last};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        bytes_sent++;
        if (last) requests++;
    endtask

    task automatic send_text(input string s, input bit vary, input int bad);
        logic [7:0] c;
        int b;
        for (int i = 0; i < s.len(); i++) begin
            c = s[i];
            if (vary && ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) &&
                $urandom_range(1) == 1) c ^= 8'h20;
            if (i == bad) begin
                // flip any bit but the case bit, so the byte really differs
                b = $urandom_range(6);
                if (b >= 5) b++;
                c ^= 8'(1 << b);
            end
            send_byte(c, 1'b0);
        end
    endtask

    task automatic send_crlf();
        send_byte(CH_CR, 1'b0);
        send_byte(CH_LF, 1'b0);
    endtask

    task automatic send_line(input string s);
        send_text(s, 1'b0, -1);
        send_crlf();
    endtask

    task automatic send_head(input string first, input bit conn, input bit upg, input bit key);
        send_line(first);
        if (conn) send_line("Connection: Upgrade");
        if (upg) send_line("Upgrade: websocket");
        if (key) send_line("Sec-WebSocket-Key: a2V5");
    endtask

    task automatic send_key_value(input int len, input bit noisy);
        for (int i = 0; i < len; i++) begin
            if (noisy && $urandom_range(7) == 0) send_byte(CH_CR, 1'b0);
            else send_byte(8'($urandom_range(33, 126)), 1'b0);
        end
    endtask

    task automatic header_line(input header_kind_t kind, input bit clean);
        int bad;
        bad = (clean || $urandom_range(3) != 0) ? -1 : int'($urandom_range(18));
        case (kind)
            HDR_CONN: send_text("Connection: Upgrade", 1'b1, bad);
            HDR_UPG: send_text("Upgrade: websocket", 1'b1, bad);
            HDR_KEY: begin
                send_text("Sec-WebSocket-Key: ", 1'b1, bad);
                send_key_value($urandom_range(1, 16), !clean);
            end
            HDR_NEAR: begin
                case ($urandom_range(4))
                    0: send_text("Connection: keep-alive, Upgrade", 1'b1, -1);
                    1: send_text("Upgrade: websocket2", 1'b1, -1);
                    2: send_text("Connection:Upgrade", 1'b1, -1);
                    3: send_text("Sec-WebSocket-Key:x", 1'b1, -1);
                    default: send_text("Sec-WebSocket-Version: 13", 1'b1, -1);
                endcase
            end
            default: begin
                for (int i = $urandom_range(40); i > 0; i--) send_byte(8'($urandom), 1'b0);
            end
        endcase
        send_crlf();
    endtask

    task automatic random_request();
        header_kind_t order[6];
        header_kind_t tmp;
        int n;
        int pick;
        bit clean;
        clean = ($urandom_range(99) < 70);
        if (!clean && $urandom_range(5) == 0) begin
            // request cut short inside the method
            send_text("GET", 1'b0, -1);
            send_byte(8'($urandom), 1'b1);
            return;
        end
        send_text("GET /", 1'b0, (clean || $urandom_range(2) != 0) ? -1 : $urandom_range(4));
        send_key_value($urandom_range(6), 1'b0);
        send_text(" HTTP/1.1", 1'b0, -1);
        send_crlf();
        if (clean) begin
            order[0] = HDR_CONN;
            order[1] = HDR_UPG;
            order[2] = HDR_KEY;
            for (int i = 3; i < 6; i++)
                order[i] = ($urandom_range(1) == 1) ? HDR_JUNK : HDR_NEAR;
            n = 3 + $urandom_range(2);
        end else begin
            for (int i = 0; i < 6; i++) order[i] = header_kind_t'($urandom_range(4));
            n = $urandom_range(6);
        end
        for (int k = n; k > 0; k--) begin
            pick = $urandom_range(k - 1);
            tmp = order[pick];
            order[pick] = order[k-1];
            header_line(tmp, clean);
        end
        case ($urandom_range(clean ? 5 : 9))
            6: send_byte(8'($urandom), 1'b1);
            7: begin
                // the LF of the blank line is the final byte
                send_byte(CH_CR, 1'b0);
                send_byte(CH_LF, 1'b1);
            end
            8: send_byte(CH_CR, 1'b1);
            9: begin
                send_text("Sec-WebSocket-Key: ", 1'b1, -1);
                send_key_value($urandom_range(1, 5), 1'b0);
                send_byte(8'($urandom), 1'b1);
            end
            default: begin
                send_crlf();
                for (int i = $urandom_range(4); i > 0; i--) send_byte(8'($urandom), 1'b0);
                send_byte(8'($urandom), 1'b1);
            end
        endcase
    endtask

    task automatic test_request_ok();
        send_line("GET / HTTP/1.1");
        send_line("CONNECTION: UPGRADE");
        send_line("upgrade: WebSocket");
        send_line("Host: example");
        send_line("sEC-wEBsOCKET-kEY: dGhlIHNhbXBsZQ==");
        send_crlf();
        send_text("xyz", 1'b0, -1);
        send_byte(8'hFF, 1'b1);
    endtask

    task automatic test_method_errors();
        send_text("GE", 1'b0, -1);
        send_byte("T", 1'b1);
        // blank first line: verdict at once, the rest is ignored
        send_crlf();
        send_text("abc", 1'b0, -1);
        send_byte(8'h00, 1'b1);
        send_head("get / HTTP/1.1", 1'b1, 1'b1, 1'b1);
        send_crlf();
        send_byte("z", 1'b1);
    endtask

    task automatic test_header_errors();
        send_head("GET / a", 1'b0, 1'b1, 1'b1);
        send_crlf();
        send_byte("z", 1'b1);
        send_head("GET / b", 1'b0, 1'b1, 1'b1);
        send_line("Connection: Upgraded");
        send_line("Connection: keep-alive");
        send_crlf();
        send_byte("z", 1'b1);
        send_head("GET / c", 1'b1, 1'b0, 1'b1);
        send_line("Upgrade: websockets");
        send_crlf();
        send_byte("z", 1'b1);
        send_head("GET / d", 1'b1, 1'b1, 1'b0);
        send_crlf();
        send_byte("z", 1'b1);
    endtask

    task automatic test_key_cases();
        // second key replaces the first
        send_head("GET /", 1'b1, 1'b1, 1'b1);
        send_line("sec-websocket-key: QQ==");
        send_crlf();
        send_byte("z", 1'b1);
        // replacement key line cut off by the final byte
        send_head("GET /", 1'b1, 1'b1, 1'b1);
        send_text("Sec-WebSocket-Key: abc", 1'b0, -1);
        send_byte("d", 1'b1);
        // value of bare CRs only
        send_head("GET /", 1'b1, 1'b1, 1'b0);
        send_text("Sec-WebSocket-Key: ", 1'b0, -1);
        send_byte(CH_CR, 1'b0);
        send_byte(CH_CR, 1'b0);
        send_crlf();
        send_crlf();
        send_byte("z", 1'b1);
        // bare CR and bare LF inside a key value; the lone LF is a key byte
        send_head("GET /", 1'b1, 1'b1, 1'b0);
        send_text("Sec-WebSocket-Key: ab", 1'b0, -1);
        send_byte(CH_CR, 1'b0);
        send_text("cd", 1'b0, -1);
        send_byte(CH_LF, 1'b0);
        send_text("e", 1'b0, -1);
        send_crlf();
        send_crlf();
        send_byte("z", 1'b1);
        // empty key value
        send_head("GET /", 1'b1, 1'b1, 1'b0);
        send_line("Sec-WebSocket-Key: ");
        send_crlf();
        send_byte("z", 1'b1);
    endtask

    task automatic test_byte_extremes();
        // line long enough to saturate the position count, with 00 and FF in it
        send_head("GET /", 1'b1, 1'b1, 1'b1);
        send_byte(8'h00, 1'b0);
        for (int i = 0; i < 40; i++) send_byte(8'($urandom), 1'b0);
        send_byte(8'hFF, 1'b0);
        send_crlf();
        send_byte(CH_CR, 1'b0);
        send_byte(CH_LF, 1'b1);
        send_head("GET /", 1'b1, 1'b1, 1'b1);
        send_byte(CH_CR, 1'b1);
        // final LF closes the key line, then the verdict
        send_head("GET /", 1'b1, 1'b1, 1'b0);
        send_text("Sec-WebSocket-Key: k", 1'b0, -1);
        send_byte(CH_CR, 1'b0);
        send_byte(CH_LF, 1'b1);
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_len = 400;
        hold_reqs++;
        send_head("GET /", 1'b1, 1'b1, 1'b0);
        send_text("Sec-WebSocket-Key: ", 1'b0, -1);
        send_key_value(24, 1'b0);
        send_crlf();
        send_crlf();
        send_byte("z", 1'b1);
    endtask

    task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                       input int budget);
        int start;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        start = bytes_sent;
        while (bytes_sent - start < budget) random_request();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        send_idle_pct = 9;
        recv_idle_pct = 75;
        @(negedge aclk);

        test_request_ok();
        test_method_errors();
        test_header_errors();
        test_key_cases();
        test_byte_extremes();
        test_backpressure();
        test_random_traffic(9, 75, 120);
        test_random_traffic(75, 9, 120);
        test_random_traffic(0, 0, 120);

        s_valid <= 1'b0;
        while (awaited_beats.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
        leftover = awaited_beats.size();
        if (leftover != 0) $display("%0d expected result beats never arrived", leftover);

        $display("%0d requests in %0d bytes; %0d key beats and %0d verdicts checked",
                 requests, bytes_sent, key_beats, verdict_beats);
        $display("verdicts: ok %0d, bad method %0d, bad connection %0d, bad upgrade %0d",
                 verdict_count[0], verdict_count[1], verdict_count[2], verdict_count[3]);
        $display("no key %0d; %0d mismatches", verdict_count[4], mismatches);
        if (mismatches == 0 && leftover == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #(5_000_000);
        $display("run timed out with %0d result beats outstanding", awaited_beats.size());
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
src/wsu_pkg.sv
src/wsu_front.sv
src/wsu_queue.sv
src/wsu_back.sv
src/ws_upgrade_request_checker.sv
tb/sv/testbench.sv
